>>> design/wcse_pkg.sv
// Shared types and constants of the WebAssembly custom section extractor.
`default_nettype none

package wcse_pkg;

  localparam int unsigned MaxNameBytes = 32;
  localparam int unsigned HeaderBytes  = 8;
  localparam int unsigned NameBits     = 8 * MaxNameBytes;

  // Parse phases.
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_SECLEN  = 3'd2;
  localparam logic [2:0] PH_NAMELEN = 3'd3;
  localparam logic [2:0] PH_NAME    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  // Done status codes; ST_NONE is internal and never leaves the block.
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_NONE      = 2'd3;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_NAME_LENGTH = 3'd0;
  localparam logic [2:0] CFG_NAME_WORD_0 = 3'd1;
  localparam logic [2:0] CFG_NAME_WORD_1 = 3'd2;
  localparam logic [2:0] CFG_NAME_WORD_2 = 3'd3;
  localparam logic [2:0] CFG_NAME_WORD_3 = 3'd4;

  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic       payload_end;
    logic [1:0] status;
    logic       run_last;
  } result_t;

endpackage

`default_nettype wire

>>> design/wasm_custom_section_extractor_core.sv
// Top level of the WebAssembly custom section extractor: byte parser and result queue.
//
// Usage: the module image enters one byte per request on the input channel
// (in_valid_i, in_stall_o, data_byte_i, final_byte_i), final_byte_i marking
// the last byte of an image. The eight header bytes are skipped, then the
// sections are walked. The payload of the first custom section whose name
// equals the configured name leaves on the output channel, one request per
// byte, the last marked by payload_end_o, followed by a done request with
// status found. Otherwise the done request has status malformed, or absent
// at the final byte. Further bytes after a done give nothing until the
// final byte, after which parsing starts again on a new image.
// Each input byte is parsed in the cycle it is accepted and its results
// (at most two) enter a two-entry output queue, so the first result is shown
// in the cycle after acceptance. One byte is taken per cycle while each byte
// causes at most one result; a byte that causes two results (the last
// payload byte and its done) holds the input until its first leaves, as the
// queue drains a single request per cycle. The configuration port (cfg_we_i,
// cfg_index_i, cfg_data_i) is to be written only while the block is idle;
// the block does not enforce it. Reset clears the parser, the queue and the
// name. When the receiver stalls, the head request holds and the input
// channel stalls as soon as the queue cannot take a further byte's results.
`default_nettype none

module wasm_custom_section_extractor_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // Input byte channel.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        final_byte_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             item_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic             payload_end_o,
  output logic [1:0]       status_o,
  output logic             run_last_o
);

  // Configuration registers.
  logic [5:0]                      name_len_q;
  logic [wcse_pkg::NameBits-1:0]   name_q;

  // Parse state.
  logic [2:0]  phase_q, phase_d;
  logic [2:0]  hdr_q, hdr_d;
  logic [31:0] val_q, val_d;
  logic [5:0]  shift_q, shift_d;
  logic [31:0] rem_q, rem_d;
  logic        custom_q, custom_d;
  logic [5:0]  idx_q, idx_d;
  logic        matches_q, matches_d;
  logic        done_q, done_d;

  // Output queue: slot 0 is the head.
  wcse_pkg::result_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]        count_q, count_d;

  logic        in_accept;
  logic        out_pop;
  logic [31:0] rem_dec;
  logic [31:0] vt_part;
  logic [31:0] val_take;
  logic [5:0]  shift_take;
  logic        vt_last;
  logic [7:0]  wanted;
  logic [5:0]  idx_inc;
  logic        name_ok;
  logic [1:0]  st;
  logic        pay_v;
  logic        pay_end;
  wcse_pkg::result_t res_pay, res_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_len_q <= '0;
      name_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wcse_pkg::CFG_NAME_LENGTH: name_len_q <= cfg_data_i[5:0];
        wcse_pkg::CFG_NAME_WORD_0: name_q[63:0]    <= cfg_data_i;
        wcse_pkg::CFG_NAME_WORD_1: name_q[127:64]  <= cfg_data_i;
        wcse_pkg::CFG_NAME_WORD_2: name_q[191:128] <= cfg_data_i;
        wcse_pkg::CFG_NAME_WORD_3: name_q[255:192] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The queue only takes a byte when it will be empty after this cycle's pop,
  // so both results of a byte always fit.
  assign out_valid_o = (count_q != 2'd0);
  assign out_pop     = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((count_q == 2'd0) || ((count_q == 2'd1) && !out_stall_i));
  assign in_accept   = in_valid_i && !in_stall_o;

  // LEB128 step: each new group lands above the bits already gathered, so an
  // OR equals the addition; groups past bit 31 are dropped.
  assign rem_dec    = rem_q - 32'd1;
  assign vt_part    = (shift_q < 6'd32) ? ({25'd0, data_byte_i[6:0]} << shift_q[4:0]) : '0;
  assign val_take   = val_q | vt_part;
  assign shift_take = (shift_q < 6'd35) ? shift_q + 6'd7 : shift_q;
  assign vt_last    = !data_byte_i[7];

  assign wanted  = name_q[{idx_q[4:0], 3'b000} +: 8];
  assign idx_inc = idx_q + 6'd1;
  assign name_ok = (val_take == {26'd0, name_len_q}) &&
                   (name_len_q <= 6'(wcse_pkg::MaxNameBytes));

  always_comb begin
    phase_d   = phase_q;
    hdr_d     = hdr_q;
    val_d     = val_q;
    shift_d   = shift_q;
    rem_d     = rem_q;
    custom_d  = custom_q;
    idx_d     = idx_q;
    matches_d = matches_q;
    done_d    = done_q;
    st        = wcse_pkg::ST_NONE;
    pay_v     = 1'b0;
    pay_end   = 1'b0;

    if (!done_q) begin
      unique case (phase_q)
        wcse_pkg::PH_HEADER: begin
          if (hdr_q == 3'(wcse_pkg::HeaderBytes - 1)) begin
            phase_d = wcse_pkg::PH_TYPE;
          end else begin
            hdr_d = hdr_q + 3'd1;
          end
        end
        wcse_pkg::PH_TYPE: begin
          custom_d = (data_byte_i == 8'd0);
          val_d    = '0;
          shift_d  = '0;
          phase_d  = wcse_pkg::PH_SECLEN;
        end
        wcse_pkg::PH_SECLEN: begin
          val_d   = val_take;
          shift_d = shift_take;
          if (vt_last) begin
            if (val_take == wcse_pkg::AllOnes) begin
              st = wcse_pkg::ST_MALFORMED;
            end else if (custom_q) begin
              if (val_take == 32'd0) begin
                st = wcse_pkg::ST_MALFORMED;
              end else begin
                rem_d   = val_take;
                val_d   = '0;
                shift_d = '0;
                phase_d = wcse_pkg::PH_NAMELEN;
              end
            end else begin
              rem_d   = val_take;
              phase_d = (val_take != 32'd0) ? wcse_pkg::PH_SKIP : wcse_pkg::PH_TYPE;
            end
          end
        end
        wcse_pkg::PH_NAMELEN: begin
          rem_d   = rem_dec;
          val_d   = val_take;
          shift_d = shift_take;
          if (!vt_last) begin
            if (rem_dec == 32'd0) begin
              st = wcse_pkg::ST_MALFORMED;
            end
          end else if ((val_take == wcse_pkg::AllOnes) || (val_take > rem_dec)) begin
            st = wcse_pkg::ST_MALFORMED;
          end else begin
            matches_d = name_ok;
            idx_d     = '0;
            if (!name_ok) begin
              phase_d = (rem_dec != 32'd0) ? wcse_pkg::PH_SKIP : wcse_pkg::PH_TYPE;
            end else if (name_len_q != 6'd0) begin
              phase_d = wcse_pkg::PH_NAME;
            end else if (rem_dec != 32'd0) begin
              phase_d = wcse_pkg::PH_PAYLOAD;
            end else begin
              st = wcse_pkg::ST_FOUND;
            end
          end
        end
        wcse_pkg::PH_NAME: begin
          rem_d = rem_dec;
          if (data_byte_i != wanted) begin
            matches_d = 1'b0;
            phase_d   = (rem_dec != 32'd0) ? wcse_pkg::PH_SKIP : wcse_pkg::PH_TYPE;
          end else begin
            idx_d = idx_inc;
            if (idx_inc == name_len_q) begin
              if (rem_dec != 32'd0) begin
                phase_d = wcse_pkg::PH_PAYLOAD;
              end else begin
                st = wcse_pkg::ST_FOUND;
              end
            end
          end
        end
        wcse_pkg::PH_PAYLOAD: begin
          rem_d   = rem_dec;
          pay_v   = 1'b1;
          pay_end = (rem_dec == 32'd0);
          if (rem_dec == 32'd0) begin
            st = wcse_pkg::ST_FOUND;
          end
        end
        default: begin
          // Skipping the body of a section of no interest.
          rem_d = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_d = wcse_pkg::PH_TYPE;
          end
        end
      endcase

      // Running out of image in the header or between sections means absent;
      // anywhere else within a section means the image is cut short.
      if ((st == wcse_pkg::ST_NONE) && final_byte_i) begin
        st = ((phase_d == wcse_pkg::PH_TYPE) || (phase_d == wcse_pkg::PH_HEADER)) ?
             wcse_pkg::ST_ABSENT : wcse_pkg::ST_MALFORMED;
      end
      if (st != wcse_pkg::ST_NONE) begin
        done_d = 1'b1;
      end
    end

    // The final byte always restarts the parser for the next image.
    if (final_byte_i) begin
      phase_d   = wcse_pkg::PH_HEADER;
      hdr_d     = '0;
      val_d     = '0;
      shift_d   = '0;
      rem_d     = '0;
      custom_d  = 1'b0;
      idx_d     = '0;
      matches_d = 1'b0;
      done_d    = 1'b0;
    end
  end

  always_comb begin
    res_pay.item_kind    = wcse_pkg::KIND_PAYLOAD;
    res_pay.payload_byte = data_byte_i;
    res_pay.payload_end  = pay_end;
    res_pay.status       = wcse_pkg::ST_FOUND;
    res_pay.run_last     = (st == wcse_pkg::ST_NONE);

    res_done.item_kind    = wcse_pkg::KIND_DONE;
    res_done.payload_byte = '0;
    res_done.payload_end  = 1'b0;
    res_done.status       = st;
    res_done.run_last     = 1'b1;

    slot0_d = slot0_q;
    slot1_d = slot1_q;
    count_d = count_q;
    if (in_accept) begin
      slot0_d = pay_v ? res_pay : res_done;
      slot1_d = res_done;
      count_d = 2'(pay_v) + 2'(st != wcse_pkg::ST_NONE);
    end else if (out_pop) begin
      slot0_d = slot1_q;
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wcse_pkg::PH_HEADER;
      hdr_q     <= '0;
      val_q     <= '0;
      shift_q   <= '0;
      rem_q     <= '0;
      custom_q  <= 1'b0;
      idx_q     <= '0;
      matches_q <= 1'b0;
      done_q    <= 1'b0;
      count_q   <= '0;
    end else begin
      if (in_accept) begin
        phase_q   <= phase_d;
        hdr_q     <= hdr_d;
        val_q     <= val_d;
        shift_q   <= shift_d;
        rem_q     <= rem_d;
        custom_q  <= custom_d;
        idx_q     <= idx_d;
        matches_q <= matches_d;
        done_q    <= done_d;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign item_kind_o    = slot0_q.item_kind;
  assign payload_byte_o = slot0_q.payload_byte;
  assign payload_end_o  = slot0_q.payload_end;
  assign status_o       = slot0_q.status;
  assign run_last_o     = slot0_q.run_last;

  // A done request always closes the results of its byte and carries a real status.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_kind_o == wcse_pkg::KIND_DONE)) |->
      (run_last_o && (status_o != wcse_pkg::ST_NONE)))
    else $error("done request without run_last or with no status");

  // The last payload byte is always followed by its done request.
  a_end_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_pop && (item_kind_o == wcse_pkg::KIND_PAYLOAD) && payload_end_o) |->
      (!run_last_o && (count_q == 2'd2)))
    else $error("last payload byte not followed by done");

  // The queue never holds more than two requests.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue overflow");

  // A byte is only taken when the queue will have room for both its results.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (count_q <= 2'd2))
    else $error("byte accepted without room in the queue");

endmodule

`default_nettype wire

>>> tb/sv/tb_wasm_custom_section_extractor_core.sv
// Self-checking testbench for the WebAssembly custom section extractor core.

module tb_wasm_custom_section_extractor_core;
  import wcse_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned IdlePercent  = 12;
  localparam int unsigned SettingBytes = 180;
  localparam int unsigned NumSettings  = 8;

  // How a generated image is put together.
  typedef enum int {IMG_CLEAN, IMG_CUT, IMG_BROKEN, IMG_NOISE} image_shape_e;

  // Malformed constructs that end the walk early.
  typedef enum int {
    BRK_ALL_ONES_LEN,
    BRK_EMPTY_CUSTOM,
    BRK_NAME_TOO_LONG,
    BRK_NAMELEN_OVERRUN,
    BRK_ALL_ONES_NAMELEN
  } breakage_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } image_byte_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [2:0]  cfg_index_i  = CFG_NAME_LENGTH;
  logic [63:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i  = '0;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        item_kind_o;
  logic [7:0]  payload_byte_o;
  logic        payload_end_o;
  logic [1:0]  status_o;
  logic        run_last_o;

  wasm_custom_section_extractor_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_o    (item_kind_o),
    .payload_byte_o (payload_byte_o),
    .payload_end_o  (payload_end_o),
    .status_o       (status_o),
    .run_last_o     (run_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Our copy of the name registers.
  logic [5:0]        want_len   = '0;
  logic [3:0][63:0]  want_words = '0;

  // Mirror of the parser state.
  logic [2:0]  ps_phase     = PH_HEADER;
  logic [2:0]  ps_hdr_count = '0;
  logic [31:0] ps_leb_value = '0;
  logic [5:0]  ps_leb_shift = '0;
  logic [31:0] ps_sec_left  = '0;
  logic        ps_custom    = 1'b0;
  logic [5:0]  ps_name_idx  = '0;
  logic        ps_name_ok   = 1'b0;
  logic        ps_done      = 1'b0;

  result_t     section_results_q[$];
  image_byte_t image_bytes_q[$];
  logic [7:0]  image_buf[$];

  int unsigned bytes_pushed   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  bit          byte_taken     = 1'b0;

  // A stretch of the run in which neither side idles at random.
  wire calm = (cycle_count >= 600) && (cycle_count < 1400);

  function automatic logic [7:0] wanted_name_byte(input logic [5:0] idx);
    logic [4:0] i;
    i = idx[4:0];
    return want_words[i[4:3]][8 * i[2:0] +: 8];
  endfunction

  // Folds one LEB128 byte into the running value; true on the closing byte.
  // Bits beyond bit 31 fall away and the shift stops growing at 35.
  function automatic bit leb_take(input logic [7:0] b);
    logic [63:0] part;
    if (ps_leb_shift < 32) begin
      part = 64'(b[6:0]) << ps_leb_shift;
      ps_leb_value = ps_leb_value + part[31:0];
    end
    if (ps_leb_shift < 35) ps_leb_shift = ps_leb_shift + 6'd7;
    return !b[7];
  endfunction

  task automatic reset_parser();
    ps_phase     = PH_HEADER;
    ps_hdr_count = '0;
    ps_leb_value = '0;
    ps_leb_shift = '0;
    ps_sec_left  = '0;
    ps_custom    = 1'b0;
    ps_name_idx  = '0;
    ps_name_ok   = 1'b0;
    ps_done      = 1'b0;
  endtask

  // Advances the mirrored parser by one byte and queues the results it gives.
  task automatic parse_image_byte(input logic [7:0] b, input logic fin);
    result_t    outs[2];
    int         n;
    logic [1:0] st;
    n  = 0;
    st = ST_NONE;
    if (ps_done) begin
      // Everything up to the final byte of this image is ignored.
      if (fin) reset_parser();
    end else begin
      case (ps_phase)
        PH_HEADER: begin
          if (ps_hdr_count + 1 >= HeaderBytes) ps_phase = PH_TYPE;
          else ps_hdr_count = ps_hdr_count + 3'd1;
        end
        PH_TYPE: begin
          ps_custom    = (b == 8'h00);
          ps_leb_value = '0;
          ps_leb_shift = '0;
          ps_phase     = PH_SECLEN;
        end
        PH_SECLEN: begin
          if (leb_take(b)) begin
            if (ps_leb_value == AllOnes) begin
              st = ST_MALFORMED;
            end else if (ps_custom) begin
              if (ps_leb_value == 0) begin
                st = ST_MALFORMED;
              end else begin
                ps_sec_left  = ps_leb_value;
                ps_leb_value = '0;
                ps_leb_shift = '0;
                ps_phase     = PH_NAMELEN;
              end
            end else begin
              ps_sec_left = ps_leb_value;
              ps_phase    = (ps_sec_left != 0) ? PH_SKIP : PH_TYPE;
            end
          end
        end
        PH_NAMELEN: begin
          ps_sec_left = ps_sec_left - 1;
          if (!leb_take(b)) begin
            if (ps_sec_left == 0) st = ST_MALFORMED;
          end else if (ps_leb_value == AllOnes || ps_leb_value > ps_sec_left) begin
            st = ST_MALFORMED;
          end else begin
            ps_name_ok  = (ps_leb_value == 32'(want_len)) && (want_len <= MaxNameBytes);
            ps_name_idx = '0;
            if (!ps_name_ok) ps_phase = (ps_sec_left != 0) ? PH_SKIP : PH_TYPE;
            else if (want_len != 0) ps_phase = PH_NAME;
            else if (ps_sec_left != 0) ps_phase = PH_PAYLOAD;
            else st = ST_FOUND;
          end
        end
        PH_NAME: begin
          ps_sec_left = ps_sec_left - 1;
          if (b != wanted_name_byte(ps_name_idx)) begin
            ps_name_ok = 1'b0;
            ps_phase   = (ps_sec_left != 0) ? PH_SKIP : PH_TYPE;
          end else begin
            ps_name_idx = ps_name_idx + 6'd1;
            if (ps_name_idx == want_len) begin
              if (ps_sec_left != 0) ps_phase = PH_PAYLOAD;
              else st = ST_FOUND;
            end
          end
        end
        PH_PAYLOAD: begin
          ps_sec_left = ps_sec_left - 1;
          // Payload requests carry the zero status code.
          outs[n] = '{item_kind: KIND_PAYLOAD, payload_byte: b,
                      payload_end: (ps_sec_left == 0), status: ST_FOUND, run_last: 1'b0};
          n++;
          if (ps_sec_left == 0) st = ST_FOUND;
        end
        default: begin
          ps_sec_left = ps_sec_left - 1;
          if (ps_sec_left == 0) ps_phase = PH_TYPE;
        end
      endcase

      // An image that stops at a section boundary or in its header lacks the
      // section; one that stops anywhere else is broken.
      if (st == ST_NONE && fin)
        st = (ps_phase == PH_TYPE || ps_phase == PH_HEADER) ? ST_ABSENT : ST_MALFORMED;
      if (st != ST_NONE) begin
        outs[n] = '{item_kind: KIND_DONE, payload_byte: 8'h00,
                    payload_end: 1'b0, status: st, run_last: 1'b0};
        n++;
        ps_done = 1'b1;
      end
      if (fin) reset_parser();
      if (n > 0) begin
        outs[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++) section_results_q.push_back(outs[i]);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Image construction.
  // ---------------------------------------------------------------------------

  function automatic int leb_groups(input logic [31:0] v);
    int g;
    g = 1;
    while (g < 5 && (v >> (7 * g)) != 0) g++;
    return g;
  endfunction

  // Appends v as LEB128, stretched by pad redundant continuation bytes.
  task automatic add_leb(input logic [31:0] v, input int pad);
    int          total;
    logic [63:0] w;
    total = leb_groups(v) + pad;
    w     = 64'(v);
    for (int i = 0; i < total; i++)
      image_buf.push_back({1'(i < total - 1), 7'(w >> (7 * i))});
  endtask

  task automatic add_header(input int count);
    repeat (count) image_buf.push_back(8'($urandom));
  endtask

  task automatic add_plain_section(input bit huge);
    int body;
    body = $urandom_range(0, 6);
    image_buf.push_back(8'($urandom_range(1, 255)));
    // A huge length runs past the end of the image.
    if (huge) add_leb($urandom_range(32'h100, 32'hFFFF_FFFE), 0);
    else add_leb(body, $urandom_range(0, 3));
    repeat (body) image_buf.push_back(8'($urandom));
  endtask

  // Custom section whose name bytes come from the configured name, with the
  // byte at flip_at spoiled (none when negative).
  task automatic add_custom(input int name_len, input int flip_at, input int body_len);
    int         pad;
    logic [7:0] nb;
    pad = $urandom_range(0, 1);
    image_buf.push_back(8'h00);
    add_leb(leb_groups(name_len) + pad + name_len + body_len, $urandom_range(0, 1));
    add_leb(name_len, pad);
    for (int i = 0; i < name_len; i++) begin
      nb = wanted_name_byte(6'(i));
      if (i == flip_at) nb = nb ^ (8'h01 << $urandom_range(0, 7));
      image_buf.push_back(nb);
    end
    repeat (body_len) image_buf.push_back(8'($urandom));
  endtask

  task automatic add_random_section();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) add_plain_section(1'b1);
    else if (pick < 35) add_plain_section(1'b0);
    else if (pick < 62) add_custom(want_len, -1, $urandom_range(0, 6));
    else if (pick < 80 && want_len != 0)
      add_custom(want_len, $urandom_range(0, want_len - 1), $urandom_range(0, 6));
    else if (pick < 90) add_custom(want_len + 1, -1, $urandom_range(0, 4));
    else add_custom($urandom_range(0, 8), -1, $urandom_range(0, 4));
  endtask

  task automatic add_breakage(input breakage_e kind);
    int len;
    case (kind)
      BRK_ALL_ONES_LEN: begin
        // Any top nibble in the fifth byte is dropped, leaving all ones.
        image_buf.push_back(8'($urandom));
        repeat (4) image_buf.push_back(8'hFF);
        image_buf.push_back(8'h0F | (8'($urandom_range(0, 7)) << 4));
      end
      BRK_EMPTY_CUSTOM: begin
        image_buf.push_back(8'h00);
        add_leb(0, $urandom_range(0, 2));
      end
      BRK_NAME_TOO_LONG: begin
        len = $urandom_range(1, 6);
        image_buf.push_back(8'h00);
        add_leb(len, 0);
        add_leb(len + $urandom_range(0, 3), 0);
      end
      BRK_NAMELEN_OVERRUN: begin
        image_buf.push_back(8'h00);
        add_leb(1, 0);
        image_buf.push_back(8'h80 | 8'($urandom));
      end
      BRK_ALL_ONES_NAMELEN: begin
        image_buf.push_back(8'h00);
        add_leb(8 + $urandom_range(0, 4), 0);
        add_leb(AllOnes, 0);
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 3)) image_buf.push_back(8'($urandom));
  endtask

  // Hands the first keep bytes of the image to the driver, the last one final.
  task automatic queue_image(input int keep);
    for (int i = 0; i < keep; i++)
      image_bytes_q.push_back('{data: image_buf[i], fin: (i == keep - 1)});
    bytes_pushed += keep;
  endtask

  task automatic send_image(input image_shape_e shape);
    int keep;
    image_buf.delete();
    if (shape == IMG_NOISE) begin
      add_header($urandom_range(1, 30));
    end else begin
      add_header(HeaderBytes);
      repeat ($urandom_range(0, 4)) add_random_section();
      if (shape == IMG_BROKEN) begin
        add_breakage(breakage_e'($urandom_range(0, 4)));
        repeat ($urandom_range(0, 2)) add_random_section();
      end
    end
    keep = image_buf.size();
    if (shape == IMG_CUT && keep > 1) keep = $urandom_range(1, keep - 1);
    queue_image(keep);
  endtask

  // Writes all five name registers, the length word carrying random upper bits.
  task automatic load_name(input logic [5:0] len);
    logic [63:0] words[5];
    logic [2:0]  regs[5];
    regs = '{CFG_NAME_LENGTH, CFG_NAME_WORD_0, CFG_NAME_WORD_1,
             CFG_NAME_WORD_2, CFG_NAME_WORD_3};
    for (int i = 0; i < 5; i++) words[i] = {$urandom, $urandom};
    words[0][5:0] = len;
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= words[i];
      @(negedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    want_len   = len;
    want_words = {words[4], words[3], words[2], words[1]};
  endtask

  // Waits until every byte is taken and every result is in, then a little more.
  task automatic settle();
    while (bytes_accepted != bytes_pushed || section_results_q.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver, acceptance, stall and checking.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : drive_bytes
    image_byte_t nxt;
    // A request that is still waiting stays on the wires untouched.
    if (rst_ni && !(in_valid_i && !byte_taken)) begin
      if (image_bytes_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePercent)) begin
        nxt = image_bytes_q.pop_front();
        in_valid_i   <= 1'b1;
        data_byte_i  <= nxt.data;
        final_byte_i <= nxt.fin;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    byte_taken = 1'b0;
  end

  always @(posedge clk_i) begin : take_bytes
    if (rst_ni && in_valid_i && !in_stall_o) begin
      byte_taken = 1'b1;
      bytes_accepted++;
      parse_image_byte(data_byte_i, final_byte_i);
    end
  end

  always @(negedge clk_i) begin : drive_stall
    out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePercent);
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (section_results_q.size() == 0) begin
        report_mismatch("unexpected result, kind", item_kind_o, 0);
      end else begin
        want = section_results_q.pop_front();
        if (item_kind_o !== want.item_kind)
          report_mismatch("item_kind", item_kind_o, want.item_kind);
        if (payload_byte_o !== want.payload_byte)
          report_mismatch("payload_byte", payload_byte_o, want.payload_byte);
        if (payload_end_o !== want.payload_end)
          report_mismatch("payload_end", payload_end_o, want.payload_end);
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (run_last_o !== want.run_last)
          report_mismatch("run_last", run_last_o, want.run_last);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of settings and images.
  // ---------------------------------------------------------------------------

  initial begin : run_settings
    logic [5:0]   len;
    int unsigned  stop_at;
    int           pick;
    image_shape_e shape;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed images: a header cut short, each kind of breakage, a match
    // followed by bytes that must be ignored, and a clean image without one.
    load_name(6'd4);
    image_buf.delete();
    add_header(3);
    queue_image(3);
    for (int k = BRK_ALL_ONES_LEN; k <= BRK_ALL_ONES_NAMELEN; k++) begin
      image_buf.delete();
      add_header(HeaderBytes);
      add_breakage(breakage_e'(k));
      queue_image(image_buf.size());
    end
    image_buf.delete();
    add_header(HeaderBytes);
    add_custom(want_len, -1, 3);
    add_plain_section(1'b0);
    queue_image(image_buf.size());
    image_buf.delete();
    add_header(HeaderBytes);
    add_plain_section(1'b0);
    queue_image(image_buf.size());
    settle();

    // Random images under several name settings, the extremes first; a
    // length above the name register's capacity must never match.
    for (int s = 0; s < NumSettings; s++) begin
      case (s)
        0: len = 6'd0;
        1: len = 6'(MaxNameBytes);
        2: len = 6'd63;
        3: len = 6'd1;
        4: len = 6'($urandom_range(MaxNameBytes + 1, 62));
        default: len = 6'($urandom_range(2, 12));
      endcase
      load_name(len);
      stop_at = bytes_pushed + SettingBytes;
      while (bytes_pushed < stop_at) begin
        pick  = $urandom_range(0, 99);
        shape = (pick < 55) ? IMG_CLEAN : (pick < 75) ? IMG_CUT :
                (pick < 90) ? IMG_BROKEN : IMG_NOISE;
        send_image(shape);
      end
      settle();
    end

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
design/wcse_pkg.sv
design/wasm_custom_section_extractor_core.sv
tb/sv/tb_wasm_custom_section_extractor_core.sv
